@@ design/assert_macros.svh @@
// Assertion macros for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: a property checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) `ASSERT_PROP(lbl, (ante) |-> (cons))

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) `ASSERT_PROP(lbl, (ante) |=> (cons))

`endif

@@ design/dahdsr_pkg.sv @@
// Shared widths, constants, register indexes and types of the DAHDSR envelope generator.
`default_nettype none

package dahdsr_pkg;

  // Default sizing of the voice state and the note-on fade.
  localparam int unsigned DEF_VOICES   = 16;
  localparam int unsigned DEF_FADE_LEN = 256;

  // Field widths.
  localparam int unsigned VOICE_W    = 4;
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned STEP_W     = 25;
  localparam int unsigned LEVEL_W    = 25;
  localparam int unsigned RECIP_W    = 32;
  localparam int unsigned POS_W      = 24;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned INV_W      = 26;
  localparam int unsigned THR_W      = 22;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 56;

  // Depth of the result queue, which also bounds requests in flight.
  localparam int unsigned OQ_DEPTH = 8;

  // Level and position limits.
  localparam logic [LEVEL_W-1:0]      ONE_Q24   = LEVEL_W'(32'h0100_0000);
  localparam logic [LEVEL_W-1:0]      LEVEL_MAX = '1;
  localparam logic signed [POS_W-1:0] POS_MAX   = 24'sh7F_FFFF;

  // Register values after reset.
  localparam logic [LEN_W-1:0]   RST_DELAY_LEN     = LEN_W'(0);
  localparam logic [LEN_W-1:0]   RST_ATTACK_LEN    = LEN_W'(2400);
  localparam logic [LEN_W-1:0]   RST_HOLD_LEN      = LEN_W'(960);
  localparam logic [LEN_W-1:0]   RST_DECAY_LEN     = LEN_W'(4800);
  localparam logic [STEP_W-1:0]  RST_ATTACK_STEP   = STEP_W'(6991);
  localparam logic [STEP_W-1:0]  RST_DECAY_STEP    = STEP_W'(1049);
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN_LEVEL = LEVEL_W'(11744051);
  localparam logic [RECIP_W-1:0] RST_RELEASE_RECIP = RECIP_W'(1789570);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LEN,
    CFG_ATTACK_LEN,
    CFG_HOLD_LEN,
    CFG_DECAY_LEN,
    CFG_ATTACK_STEP,
    CFG_DECAY_STEP,
    CFG_SUSTAIN_LEVEL,
    CFG_RELEASE_RECIP
  } cfg_idx_e;

  // Per-voice state word held in the state memory.
  typedef struct packed {
    logic                    gate;
    logic                    retrig;
    logic signed [POS_W-1:0] pos;
    logic [LEVEL_W-1:0]      env;
    logic [LEVEL_W-1:0]      fade;
    logic [LEVEL_W-1:0]      noff;
  } st_t;

  // Input request, last field in the lowest bits.
  typedef struct packed {
    logic               retrigger_level;
    logic               gate_level;
    logic [VOICE_W-1:0] voice;
  } in_t;

  // Result, last field in the lowest bits.
  typedef struct packed {
    logic [INV_W-1:0]   inverse_level;
    logic [LEVEL_W-1:0] level;
    logic [VOICE_W-1:0] voice_out;
  } out_t;

endpackage

`default_nettype wire

@@ design/dahdsr_envelope_generator_unit.sv @@
// Polyphonic DAHDSR envelope generator with per-voice state in a synchronous memory.
// A request passes stage 1 (state read), stage 2 (products and phase) and stage 3 (level
// update and write back) into the result queue. Throughput: one request per cycle while
// the queue has credit; a request for the voice of a request still in the three-stage
// read-modify-write loop on the state memory waits. Reset restores register defaults and
// marks every voice entry empty through per-entry valid bits, which read as zero state.
`default_nettype none

module dahdsr_envelope_generator_unit #(
  parameter int unsigned VOICES   = dahdsr_pkg::DEF_VOICES,
  parameter int unsigned FADE_LEN = dahdsr_pkg::DEF_FADE_LEN
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: voice [3:0], gate_level [4], retrigger_level [5], zero [7:6].
  input  logic [dahdsr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: voice_out [3:0], level [28:4], inverse_level [54:29], zero [55].
  output logic [dahdsr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [dahdsr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dahdsr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dahdsr_pkg::*;

  localparam int unsigned VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned IN_W     = $bits(in_t);
  // Floor division by FADE_LEN as a multiply by a rounded-up reciprocal; exact for
  // every level because the reciprocal error stays below one part in FADE_LEN.
  localparam int unsigned FADE_K   = LEVEL_W + $clog2(FADE_LEN);
  localparam int unsigned FM_W     = LEVEL_W + 1;
  localparam logic [FM_W-1:0] FADE_M =
    FM_W'(((64'd1 << FADE_K) + 64'(FADE_LEN) - 64'd1) / 64'(FADE_LEN));
  localparam logic signed [POS_W-1:0] FADE_START = -POS_W'(FADE_LEN);
  localparam int unsigned PA_W     = LEVEL_W + LEN_W;
  localparam int unsigned PR_W     = LEVEL_W + RECIP_W;
  localparam int unsigned PF_W     = LEVEL_W + FM_W;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = OQ_PTR_W + 1;
  localparam int unsigned IF_W     = OQ_CNT_W + 1;

  typedef enum logic [2:0] {
    PH_FADE,
    PH_DELAY,
    PH_ATTACK,
    PH_HOLD,
    PH_DECAY,
    PH_SUSTAIN,
    PH_RELEASE
  } phase_e;

  // Configuration registers.
  logic [LEN_W-1:0]   delay_len_q, attack_len_q, hold_len_q, decay_len_q;
  logic [STEP_W-1:0]  attack_step_q, decay_step_q;
  logic [LEVEL_W-1:0] sustain_level_q;
  logic [RECIP_W-1:0] release_recip_q;
  logic [LEN_W-1:0]   hold_eff;
  logic [THR_W-1:0]   thr_dl_q, thr_a_q, thr_h_q, thr_d_q;

  // State memory and its per-entry valid bits.
  st_t              mem_q [VOICES];
  logic [VOICES-1:0] ent_vld_q;
  st_t              rd_q;
  logic             rd_vld_q;

  // Input side.
  in_t               in_req;
  logic              in_range;
  logic [VIDX_W-1:0] in_addr;
  logic              hazard;
  logic [IF_W-1:0]   inflight;
  logic              in_acc;

  // Stage 1: state read back.
  logic               s1_vld_q, s1_gate_q, s1_retr_q, s1_inr_q;
  logic [VOICE_W-1:0] s1_voice_q;
  st_t                s1_st;
  logic               rise_g1, fall_g1, rise_r1;
  logic [LEVEL_W-1:0] noff1;
  logic signed [POS_W-1:0] pos1;

  // Stage 2: products registered, position and phase resolved.
  logic               s2_vld_q, s2_gate_q, s2_retr_q, s2_inr_q;
  logic               s2_rise_r_q, s2_retr_nz_q, s2_fade_new_q;
  logic [VOICE_W-1:0] s2_voice_q;
  logic [LEVEL_W-1:0] s2_e_q, s2_fade_q, s2_noff_q;
  logic signed [POS_W-1:0] s2_pos_q;
  logic [PA_W-1:0]    s2_pa_q;
  logic [PR_W-1:0]    s2_pr_q;
  logic [PF_W-1:0]    s2_pf_q;
  logic signed [POS_W-1:0] pos2;
  logic [POS_W-2:0]   pos_mag2;
  logic [LEVEL_W-1:0] fade2, drop2;
  phase_e             phase2;

  // Stage 3: level update and write back.
  logic               s3_vld_q, s3_gate_q, s3_retr_q, s3_inr_q;
  logic [VOICE_W-1:0] s3_voice_q;
  phase_e             s3_phase_q;
  logic [LEVEL_W-1:0] s3_e_q, s3_fade_q, s3_noff_q, s3_drop_q;
  logic signed [POS_W-1:0] s3_pos_q;
  logic [LEVEL_W:0]   att_sum;
  logic [LEVEL_W-1:0] e3;
  logic signed [POS_W-1:0] pos3;
  logic               wr_en;
  logic [VIDX_W-1:0]  wr_addr;
  st_t                wr_st;

  // Result queue.
  out_t                oq_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic [LEVEL_W-1:0]  out_lvl;
  out_t                push_res;
  logic                pop;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_len_q     <= RST_DELAY_LEN;
      attack_len_q    <= RST_ATTACK_LEN;
      hold_len_q      <= RST_HOLD_LEN;
      decay_len_q     <= RST_DECAY_LEN;
      attack_step_q   <= RST_ATTACK_STEP;
      decay_step_q    <= RST_DECAY_STEP;
      sustain_level_q <= RST_SUSTAIN_LEVEL;
      release_recip_q <= RST_RELEASE_RECIP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY_LEN:     delay_len_q     <= cfg_data_i[LEN_W-1:0];
        CFG_ATTACK_LEN:    attack_len_q    <= cfg_data_i[LEN_W-1:0];
        CFG_HOLD_LEN:      hold_len_q      <= cfg_data_i[LEN_W-1:0];
        CFG_DECAY_LEN:     decay_len_q     <= cfg_data_i[LEN_W-1:0];
        CFG_ATTACK_STEP:   attack_step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_DECAY_STEP:    decay_step_q    <= cfg_data_i[STEP_W-1:0];
        CFG_SUSTAIN_LEVEL: sustain_level_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_RELEASE_RECIP: release_recip_q <= cfg_data_i[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase boundaries, kept in registers; hold lasts at least one sample.
  assign hold_eff = (hold_len_q == '0) ? LEN_W'(1) : hold_len_q;

  always_ff @(posedge clk_i) begin
    thr_dl_q <= THR_W'(delay_len_q);
    thr_a_q  <= THR_W'(delay_len_q) + THR_W'(attack_len_q);
    thr_h_q  <= THR_W'(delay_len_q) + THR_W'(attack_len_q) + THR_W'(hold_eff);
    thr_d_q  <= THR_W'(delay_len_q) + THR_W'(attack_len_q) + THR_W'(hold_eff)
              + THR_W'(decay_len_q);
  end

  // Request acceptance: queue credit for every request in flight, and no request for
  // a voice whose state is still being updated.
  assign in_req   = in_t'(s_axis_tdata[IN_W-1:0]);
  assign in_range = 32'(in_req.voice) < 32'(VOICES);
  assign in_addr  = VIDX_W'(in_req.voice);
  assign hazard   = (s1_vld_q && (s1_voice_q == in_req.voice))
                 || (s2_vld_q && (s2_voice_q == in_req.voice))
                 || (s3_vld_q && (s3_voice_q == in_req.voice));
  assign inflight = IF_W'(oq_cnt_q) + IF_W'(s1_vld_q) + IF_W'(s2_vld_q) + IF_W'(s3_vld_q);
  assign s_axis_tready = (inflight < IF_W'(OQ_DEPTH)) && !hazard;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Stage valids, entry valid bits and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      ent_vld_q <= '0;
      oq_wr_q   <= '0;
      oq_rd_q   <= '0;
      oq_cnt_q  <= '0;
    end else begin
      s1_vld_q <= in_acc;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (in_acc && in_range) begin
        rd_vld_q <= ent_vld_q[in_addr];
      end
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (s3_vld_q) begin
        oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      end
      if (pop) begin
        oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      end
      oq_cnt_q <= oq_cnt_d;
    end
  end

  // State memory read on acceptance, registered into stage 1.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_voice_q <= in_req.voice;
      s1_gate_q  <= in_req.gate_level;
      s1_retr_q  <= in_req.retrigger_level;
      s1_inr_q   <= in_range;
      if (in_range) begin
        rd_q <= mem_q[in_addr];
      end
    end
  end

  // Stage 1: gate and retrigger edges against the stored flags.
  assign s1_st   = rd_vld_q ? rd_q : '0;
  assign rise_g1 = !s1_st.gate && s1_gate_q;
  assign fall_g1 = s1_st.gate && !s1_gate_q;
  assign rise_r1 = !s1_st.retrig && s1_retr_q;
  assign noff1   = fall_g1 ? s1_st.env : s1_st.noff;
  assign pos1    = rise_g1 ? ((s1_st.env != '0) ? FADE_START : '0) : s1_st.pos;

  // Stage 1 to 2: retrigger position, release drop and fade step products.
  always_ff @(posedge clk_i) begin
    s2_voice_q    <= s1_voice_q;
    s2_inr_q      <= s1_inr_q;
    s2_gate_q     <= s1_gate_q;
    s2_retr_q     <= s1_retr_q;
    s2_rise_r_q   <= rise_r1;
    s2_retr_nz_q  <= (s1_st.env != '0) && (attack_step_q != '0);
    s2_fade_new_q <= rise_g1 && (s1_st.env != '0);
    s2_e_q        <= s1_st.env;
    s2_fade_q     <= s1_st.fade;
    s2_noff_q     <= noff1;
    s2_pos_q      <= pos1;
    s2_pa_q       <= {{LEN_W{1'b0}}, s1_st.env} * {{LEVEL_W{1'b0}}, attack_len_q};
    s2_pr_q       <= {{RECIP_W{1'b0}}, noff1} * {{LEVEL_W{1'b0}}, release_recip_q};
    s2_pf_q       <= {{FM_W{1'b0}}, s1_st.env} * {{LEVEL_W{1'b0}}, FADE_M};
  end

  // Stage 2: the retrigger product stays below the position limit, so it needs no clamp.
  assign pos2 = s2_rise_r_q ? (s2_retr_nz_q ? POS_W'(s2_pa_q >> FRAC_W) : '0) : s2_pos_q;
  assign pos_mag2 = pos2[POS_W-2:0];
  assign fade2 = s2_fade_new_q ? LEVEL_W'(s2_pf_q >> FADE_K) : s2_fade_q;
  assign drop2 = LEVEL_W'(s2_pr_q >> RECIP_W);

  // Phase select; the later boundary wins.
  always_comb begin
    if (!s2_gate_q) begin
      phase2 = PH_RELEASE;
    end else if (pos2[POS_W-1]) begin
      phase2 = PH_FADE;
    end else if (pos_mag2 >= (POS_W-1)'(thr_d_q)) begin
      phase2 = PH_SUSTAIN;
    end else if (pos_mag2 >= (POS_W-1)'(thr_h_q)) begin
      phase2 = PH_DECAY;
    end else if (pos_mag2 >= (POS_W-1)'(thr_a_q)) begin
      phase2 = PH_HOLD;
    end else if (pos_mag2 >= (POS_W-1)'(thr_dl_q)) begin
      phase2 = PH_ATTACK;
    end else begin
      phase2 = PH_DELAY;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_voice_q <= s2_voice_q;
    s3_inr_q   <= s2_inr_q;
    s3_gate_q  <= s2_gate_q;
    s3_retr_q  <= s2_retr_q;
    s3_phase_q <= phase2;
    s3_e_q     <= s2_e_q;
    s3_fade_q  <= fade2;
    s3_noff_q  <= s2_noff_q;
    s3_pos_q   <= pos2;
    s3_drop_q  <= drop2;
  end

  // Stage 3: level update for the phase, clamped at zero and saturating at the top.
  assign att_sum = {1'b0, s3_e_q} + {1'b0, attack_step_q};

  always_comb begin
    case (s3_phase_q)
      PH_FADE:    e3 = (s3_e_q > s3_fade_q) ? s3_e_q - s3_fade_q : '0;
      PH_DELAY:   e3 = '0;
      PH_ATTACK:  e3 = att_sum[LEVEL_W] ? LEVEL_MAX : att_sum[LEVEL_W-1:0];
      PH_HOLD:    e3 = ONE_Q24;
      PH_DECAY:   e3 = (s3_e_q > decay_step_q) ? s3_e_q - decay_step_q : '0;
      PH_SUSTAIN: e3 = sustain_level_q;
      PH_RELEASE: begin
        if ((release_recip_q == '0) || (s3_drop_q >= s3_e_q)) begin
          e3 = '0;
        end else begin
          e3 = s3_e_q - s3_drop_q;
        end
      end
      default:    e3 = '0;
    endcase
  end

  // Position advances only while the gate is high, and saturates.
  assign pos3 = (s3_gate_q && (s3_pos_q != POS_MAX)) ? s3_pos_q + POS_W'(1) : s3_pos_q;

  // Write back; a voice outside the memory leaves all state alone.
  assign wr_en   = s3_vld_q && s3_inr_q;
  assign wr_addr = VIDX_W'(s3_voice_q);
  assign wr_st   = '{gate: s3_gate_q, retrig: s3_retr_q, pos: pos3, env: e3,
                     fade: s3_fade_q, noff: s3_noff_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_st;
    end
  end

  // Result queue.
  assign out_lvl  = s3_inr_q ? e3 : '0;
  assign push_res = '{inverse_level: INV_W'(0) - INV_W'(out_lvl), level: out_lvl,
                      voice_out: s3_voice_q};
  assign pop      = m_axis_tvalid && m_axis_tready;
  assign oq_cnt_d = oq_cnt_q + OQ_CNT_W'(s3_vld_q) - OQ_CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      oq_q[oq_wr_q] <= push_res;
    end
  end

  assign m_axis_tvalid = (oq_cnt_q != '0);
  assign m_axis_tdata  = OUT_TDATA_W'(oq_q[oq_rd_q]);

endmodule

`default_nettype wire

@@ design/dahdsr_chk.sv @@
// Port-level checker for the DAHDSR envelope generator and its bind.
`default_nettype none
`include "assert_macros.svh"

module dahdsr_chk #(
  parameter int unsigned VOICES = dahdsr_pkg::DEF_VOICES
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dahdsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import dahdsr_pkg::*;

  localparam int unsigned PEND_W = 8;

  logic              in_acc, out_acc;
  logic [PEND_W-1:0] pend_q;

  // Requests accepted whose results are not yet taken.
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PEND_W'(in_acc) - PEND_W'(out_acc);
    end
  end

  // An offered result stays until it is taken.
  `ASSERT_NEXT(out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // The inverse output is the two's complement negation of the level.
  `ASSERT_SAME(inverse_matches_level, m_axis_tvalid, (m_axis_tdata[54:29] + 26'(m_axis_tdata[28:4])) == 26'd0)

  // A voice without state always reports silence.
  `ASSERT_SAME(unknown_voice_silent, m_axis_tvalid && (32'(m_axis_tdata[3:0]) >= VOICES), m_axis_tdata[28:4] == 25'd0)

  // Every result belongs to an earlier request.
  `ASSERT_SAME(no_result_without_request, m_axis_tvalid, pend_q != '0)

  // Requests in flight never exceed the result queue.
  `ASSERT_SAME(pending_bounded, 1'b1, pend_q <= PEND_W'(OQ_DEPTH))

endmodule

bind dahdsr_envelope_generator_unit dahdsr_chk #(.VOICES(VOICES)) u_dahdsr_chk (.*);

`default_nettype wire
